[hdl/tlbpt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared constants, types and helpers for the TLB and page table translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  // address geometry
  localparam int unsigned VA_W        = 16;
  localparam int unsigned PA_W        = 16;
  localparam int unsigned LP_W        = 8;
  localparam int unsigned OFFSET_BITS = 8;
  localparam int unsigned VPN_W       = VA_W - OFFSET_BITS;

  // storage sizes (page count is a power of two)
  localparam int unsigned TLB_ENTRIES = 16;
  localparam int unsigned PAGE_COUNT  = 256;
  localparam int unsigned FRAME_COUNT = 256;

  localparam int unsigned TLB_IDX_W = $clog2(TLB_ENTRIES);
  localparam int unsigned PAGE_W    = $clog2(PAGE_COUNT);
  localparam int unsigned FRAME_W   = $clog2(FRAME_COUNT);

  localparam logic [FRAME_W-1:0]   LAST_FRAME = FRAME_W'(FRAME_COUNT - 1);
  localparam logic [TLB_IDX_W-1:0] LAST_SLOT  = TLB_IDX_W'(TLB_ENTRIES - 1);

  typedef logic [VA_W-1:0]        vaddr_t;
  typedef logic [PA_W-1:0]        paddr_t;
  typedef logic [PAGE_W-1:0]      page_t;
  typedef logic [FRAME_W-1:0]     frame_t;
  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [TLB_IDX_W-1:0]   slot_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_TLB_HIT  = 2'd0,
    ST_PT_HIT   = 2'd1,
    ST_LOADED   = 2'd2,
    ST_NO_FRAME = 2'd3
  } status_e;

  // control states
  typedef enum logic {
    FSM_IDLE,
    FSM_LOOKUP
  } fsm_e;

  // page number of a virtual address, taken modulo the page count
  function automatic page_t page_of(vaddr_t va);
    logic [VPN_W+PAGE_W-1:0] vpn_ext;
    vpn_ext = (VPN_W + PAGE_W)'(va >> OFFSET_BITS);
    return vpn_ext[PAGE_W-1:0];
  endfunction

  // byte offset within the page
  function automatic offset_t offset_of(vaddr_t va);
    return va[OFFSET_BITS-1:0];
  endfunction

  // frame and offset joined into a physical address, truncated
  function automatic paddr_t make_phys(frame_t frame, offset_t offset);
    logic [FRAME_W+OFFSET_BITS-1:0] full;
    logic [PA_W+FRAME_W+OFFSET_BITS-1:0] ext;
    full = {frame, offset};
    ext  = (PA_W + FRAME_W + OFFSET_BITS)'(full);
    return ext[PA_W-1:0];
  endfunction

  // low bits of the page number for the loaded page field
  function automatic logic [LP_W-1:0] loaded_of(page_t page);
    logic [LP_W+PAGE_W-1:0] ext;
    ext = (LP_W + PAGE_W)'(page);
    return ext[LP_W-1:0];
  endfunction

endpackage
`default_nettype wire

[hdl/tlbpt_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tlbpt_if
// Valid/ready channels for translation requests and translation responses.
// ----------------------------------------------------------------------------

// request channel: one virtual address per transaction
interface tlbpt_req_if;
  logic                   valid;
  logic                   ready;
  tlbpt_pkg::vaddr_t      virtual_address;

  modport source (output valid, output virtual_address, input ready);
  modport sink   (input valid, input virtual_address, output ready);
endinterface

// response channel: one translation result per transaction
interface tlbpt_rsp_if;
  logic                       valid;
  logic                       ready;
  tlbpt_pkg::paddr_t          physical_address;
  logic [1:0]                 status;
  logic [tlbpt_pkg::LP_W-1:0] loaded_page;

  modport source (output valid, output physical_address, output status,
                  output loaded_page, input ready);
  modport sink   (input valid, input physical_address, input status,
                  input loaded_page, output ready);
endinterface
`default_nettype wire

[hdl/tlbpt_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tlbpt_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module tlbpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[hdl/tlb_page_table_translator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Virtual to physical translation: fully associative TLB with FIFO refill in
// front of a page table with demand paging and in-order frame allocation.
//
// req_i takes one 16-bit virtual address per transaction; rsp_o returns one
// result per request: physical address, status (TLB hit, page table hit,
// page fault loaded, no free frame) and the page to fetch on a fault.
// In the idle state the accept issues the page table read into the
// synchronous RAM; the lookup state then does the TLB compare, picks the
// outcome, writes the page table, refills the TLB and registers the result
// for rsp_o. A new request is taken only once the last has left lookup.
// The output register lets a new request be accepted while a result waits;
// if rsp_o stays stalled, the second request holds in its lookup cycle and
// req_i.ready stays low until the response register frees up.
// Reset clears the TLB valid bits, the page table valid bits, the FIFO slot
// and the frame allocator; there is no clearing pass, so requests are taken
// as soon as reset is released.
// ----------------------------------------------------------------------------
module tlb_page_table_translator (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tlbpt_req_if.sink   req_i,
  tlbpt_rsp_if.source rsp_o
);

  tlbpt_pkg::fsm_e state_q, state_d;

  tlbpt_pkg::vaddr_t va_q;
  tlbpt_pkg::page_t  page_q;
  tlbpt_pkg::offset_t offset_q;

  // TLB entries
  tlbpt_pkg::page_t  tlb_page_q  [tlbpt_pkg::TLB_ENTRIES];
  tlbpt_pkg::frame_t tlb_frame_q [tlbpt_pkg::TLB_ENTRIES];
  logic [tlbpt_pkg::TLB_ENTRIES-1:0] tlb_valid_q;
  tlbpt_pkg::slot_t  tlb_next_slot_q;

  // page table valid bits and frame allocator
  logic [tlbpt_pkg::PAGE_COUNT-1:0] page_valid_q;
  tlbpt_pkg::frame_t next_free_frame_q;
  logic              frames_exhausted_q;

  // response register
  logic                          rsp_valid_q;
  tlbpt_pkg::paddr_t             rsp_addr_q;
  tlbpt_pkg::status_e            rsp_status_q;
  logic [tlbpt_pkg::LP_W-1:0]    rsp_loaded_q;

  logic              accept;
  logic              commit;
  logic              tlb_hit;
  tlbpt_pkg::slot_t  hit_idx;
  tlbpt_pkg::frame_t pt_frame;
  logic              do_refill;
  logic              do_fault;
  tlbpt_pkg::frame_t sel_frame;
  tlbpt_pkg::status_e sel_status;
  tlbpt_pkg::paddr_t sel_addr;
  logic [tlbpt_pkg::LP_W-1:0] sel_loaded;

  assign page_q   = tlbpt_pkg::page_of(va_q);
  assign offset_q = tlbpt_pkg::offset_of(va_q);

  // next state and handshake
  always_comb begin
    state_d = state_q;
    accept  = 1'b0;
    commit  = 1'b0;
    case (state_q)
      tlbpt_pkg::FSM_IDLE: begin
        accept = req_i.valid;
        if (req_i.valid) begin
          state_d = tlbpt_pkg::FSM_LOOKUP;
        end
      end
      tlbpt_pkg::FSM_LOOKUP: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          commit  = 1'b1;
          state_d = tlbpt_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = tlbpt_pkg::FSM_IDLE;
      end
    endcase
  end

  assign req_i.ready = (state_q == tlbpt_pkg::FSM_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlbpt_pkg::FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // capture the request address
  always_ff @(posedge clk_i) begin
    if (accept) begin
      va_q <= req_i.virtual_address;
    end
  end

  // page table frame store, read on accept, written on a fault
  tlbpt_ram #(
    .WIDTH (tlbpt_pkg::FRAME_W),
    .DEPTH (tlbpt_pkg::PAGE_COUNT)
  ) u_page_frame (
    .clk_i   (clk_i),
    .we_i    (do_fault),
    .waddr_i (page_q),
    .wdata_i (next_free_frame_q),
    .re_i    (accept),
    .raddr_i (tlbpt_pkg::page_of(req_i.virtual_address)),
    .rdata_o (pt_frame)
  );

  // TLB compare, lowest matching slot wins
  always_comb begin
    tlb_hit = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++) begin
      if (!tlb_hit && tlb_valid_q[i] && (tlb_page_q[i] == page_q)) begin
        tlb_hit = 1'b1;
        hit_idx = tlbpt_pkg::TLB_IDX_W'(i);
      end
    end
  end

  // outcome selection
  always_comb begin
    do_refill  = 1'b0;
    do_fault   = 1'b0;
    sel_frame  = pt_frame;
    sel_status = tlbpt_pkg::ST_PT_HIT;
    sel_loaded = '0;
    if (tlb_hit) begin
      sel_frame  = tlb_frame_q[hit_idx];
      sel_status = tlbpt_pkg::ST_TLB_HIT;
    end else if (page_valid_q[page_q]) begin
      do_refill  = commit;
    end else if (frames_exhausted_q) begin
      sel_status = tlbpt_pkg::ST_NO_FRAME;
    end else begin
      do_refill  = commit;
      do_fault   = commit;
      sel_frame  = next_free_frame_q;
      sel_status = tlbpt_pkg::ST_LOADED;
      sel_loaded = tlbpt_pkg::loaded_of(page_q);
    end
    if (sel_status == tlbpt_pkg::ST_NO_FRAME) begin
      sel_addr = '0;
    end else begin
      sel_addr = tlbpt_pkg::make_phys(sel_frame, offset_q);
    end
  end

  // TLB entry payload
  always_ff @(posedge clk_i) begin
    if (do_refill) begin
      tlb_page_q[tlb_next_slot_q]  <= page_q;
      tlb_frame_q[tlb_next_slot_q] <= sel_frame;
    end
  end

  // TLB valid bits, FIFO slot, page valid bits and frame allocator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlb_valid_q        <= '0;
      tlb_next_slot_q    <= '0;
      page_valid_q       <= '0;
      next_free_frame_q  <= '0;
      frames_exhausted_q <= 1'b0;
    end else begin
      if (do_refill) begin
        tlb_valid_q[tlb_next_slot_q] <= 1'b1;
        if (tlb_next_slot_q == tlbpt_pkg::LAST_SLOT) begin
          tlb_next_slot_q <= '0;
        end else begin
          tlb_next_slot_q <= tlb_next_slot_q + 1'b1;
        end
      end
      if (do_fault) begin
        page_valid_q[page_q] <= 1'b1;
        if (next_free_frame_q == tlbpt_pkg::LAST_FRAME) begin
          frames_exhausted_q <= 1'b1;
        end else begin
          next_free_frame_q <= next_free_frame_q + 1'b1;
        end
      end
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (commit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      rsp_addr_q   <= sel_addr;
      rsp_status_q <= sel_status;
      rsp_loaded_q <= sel_loaded;
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.physical_address = rsp_addr_q;
  assign rsp_o.status           = rsp_status_q;
  assign rsp_o.loaded_page      = rsp_loaded_q;

endmodule
`default_nettype wire
